/* rtl/rgc_pkg.sv */
package rgc_pkg;

  localparam int RMS_W         = 16;
  localparam int SUM_W         = 36;
  localparam int LEN_W         = 5;
  localparam int GCNT_W        = 3;
  localparam int ROOT_W        = SUM_W / 2;
  localparam int SREM_W        = ROOT_W + 4;
  localparam int STEP_W        = 6;
  localparam int APB_AW        = 2;
  localparam int APB_DW        = 32;

  localparam int MUL_STEPS     = RMS_W;
  localparam int DIV_STEPS     = SUM_W;
  localparam int SQRT_STEPS    = ROOT_W;

  localparam logic [LEN_W-1:0] GROUP_LEN_RESET = 5'd10;
  localparam logic [LEN_W-1:0] MAX_GROUP_LEN   = 5'd16;
  localparam int DEF_GROUPS_PER_FRAME = 8;

  // zero acts as one, above the maximum acts as the maximum
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] r;
    r = n;
    if (n == '0) begin
      r = LEN_W'(1);
    end else if (n > MAX_GROUP_LEN) begin
      r = MAX_GROUP_LEN;
    end
    return r;
  endfunction

endpackage

/* rtl/rgc_in_if.sv */
interface rgc_in_if
  import rgc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [RMS_W-1:0] rms_value;

  modport source (output valid, output rms_value, input ready);
  modport sink   (input valid, input rms_value, output ready);
endinterface

/* rtl/rgc_out_if.sv */
interface rgc_out_if
  import rgc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [RMS_W-1:0] fast_level;
  logic             frame_end;

  modport source (output valid, output fast_level, output frame_end, input ready);
  modport sink   (input valid, input fast_level, input frame_end, output ready);
endinterface

/* rtl/rms_group_combiner_unit.sv */
// channel    dir   payload                       handshake
// rms_ch     in    rms_value[15:0]               valid/ready
// level_ch   out   fast_level[15:0], frame_end   valid/ready
// apb        cfg   group_len, any address        psel/penable/pwrite, pready tied high
//
// a word that does not close a group is accepted, then runs 16 shift-add
// multiply steps; a closing word adds 36 divide steps, 18 root steps and a
// hand-off of the level to the output register
// the serial multiplier, divider and root unit share one step counter and set the rate
// synchronous reset clears the sum, the counters and the output valid
// a stalled output holds its level; the next word is still taken meanwhile,
// only a new level waits for the output register to free up
module rms_group_combiner_unit
  import rgc_pkg::*;
#(
  parameter int GROUPS_PER_FRAME = DEF_GROUPS_PER_FRAME
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  rgc_in_if.sink            rms_ch,
  rgc_out_if.source         level_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SQRT,
    S_DONE
  } state_t;

  state_t state;

  // config register
  logic [LEN_W-1:0] group_len;

  // group state
  logic [SUM_W-1:0]  square_sum;
  logic [LEN_W-1:0]  input_count;
  logic [GCNT_W-1:0] group_count;
  logic [LEN_W-1:0]  len_eff;

  // serial units
  logic [STEP_W-1:0]  step;
  logic [2*RMS_W-1:0] mcand;
  logic [RMS_W-1:0]   mplier;
  logic [SUM_W-1:0]   quo;
  logic [LEN_W-2:0]   drem;
  logic [SUM_W-1:0]   rad;
  logic [SREM_W-1:0]  srem;
  logic [ROOT_W-1:0]  root;

  // output register
  logic             out_valid;
  logic [RMS_W-1:0] out_level;
  logic             out_last;

  logic               cfg_wr;
  logic               in_take;
  logic               out_take;
  logic [SUM_W-1:0]   sum_next;
  logic [LEN_W-1:0]   dtrial;
  logic               dge;
  logic [LEN_W-1:0]   ddiff;
  logic [SUM_W-1:0]   quo_next;
  logic [SREM_W-1:0]  sshift;
  logic [SREM_W-1:0]  strial;
  logic               sge;
  logic [ROOT_W-1:0]  root_next;
  logic [GCNT_W:0]    gcount_inc;
  logic               frame_last;

  // apb: one register, any address in the word selects it
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = APB_DW'(group_len);

  assign rms_ch.ready = (state == S_IDLE);
  assign in_take      = rms_ch.valid && rms_ch.ready;
  assign out_take     = out_valid && level_ch.ready;

  assign level_ch.valid      = out_valid;
  assign level_ch.fast_level = out_level;
  assign level_ch.frame_end  = out_last;

  // shift-add square, one multiplier bit per cycle
  assign sum_next = square_sum + (mplier[0] ? SUM_W'(mcand) : '0);

  // restoring divide by the group length, one quotient bit per cycle
  assign dtrial   = {drem, quo[SUM_W-1]};
  assign dge      = (dtrial >= len_eff);
  assign ddiff    = dtrial - len_eff;
  assign quo_next = {quo[SUM_W-2:0], dge};

  // digit-by-digit square root, two radicand bits per cycle
  assign sshift    = {srem[SREM_W-3:0], rad[SUM_W-1 -: 2]};
  assign strial    = {2'b00, root, 2'b01};
  assign sge       = (sshift >= strial);
  assign root_next = {root[ROOT_W-2:0], sge};

  // frame marker
  assign gcount_inc = {1'b0, group_count} + (GCNT_W+1)'(1);
  assign frame_last = (gcount_inc >= (GCNT_W+1)'(GROUPS_PER_FRAME));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      group_len   <= GROUP_LEN_RESET;
      square_sum  <= '0;
      input_count <= '0;
      group_count <= '0;
      step        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        group_len <= pwdata[LEN_W-1:0];
      end
      if (out_take) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            mcand       <= (2*RMS_W)'(rms_ch.rms_value);
            mplier      <= rms_ch.rms_value;
            input_count <= input_count + LEN_W'(1);
            len_eff     <= eff_len(group_len);
            step        <= '0;
            state       <= S_MUL;
          end
        end

        S_MUL: begin
          square_sum <= sum_next;
          mcand      <= {mcand[2*RMS_W-2:0], 1'b0};
          mplier     <= {1'b0, mplier[RMS_W-1:1]};
          step       <= step + STEP_W'(1);
          if (step == STEP_W'(MUL_STEPS - 1)) begin
            step <= '0;
            if (input_count >= len_eff) begin
              // group closes: hand the sum to the divider and clear it
              quo         <= sum_next;
              drem        <= '0;
              square_sum  <= '0;
              input_count <= '0;
              state       <= S_DIV;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_DIV: begin
          quo  <= quo_next;
          drem <= dge ? ddiff[LEN_W-2:0] : dtrial[LEN_W-2:0];
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            step  <= '0;
            rad   <= quo_next;
            srem  <= '0;
            root  <= '0;
            state <= S_SQRT;
          end
        end

        S_SQRT: begin
          rad  <= {rad[SUM_W-3:0], 2'b00};
          srem <= sge ? (sshift - strial) : sshift;
          root <= root_next;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(SQRT_STEPS - 1)) begin
            step  <= '0;
            state <= S_DONE;
          end
        end

        S_DONE: begin
          // wait for the output register to be free
          if (!out_valid || level_ch.ready) begin
            out_valid   <= 1'b1;
            out_level   <= root[RMS_W-1:0];
            out_last    <= frame_last;
            group_count <= frame_last ? '0 : gcount_inc[GCNT_W-1:0];
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/rgc_checker.sv */
module rgc_props
  import rgc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              pready,
  input logic [APB_DW-1:0] prdata
);

  // a level stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before being taken");

  // the serial multiplier keeps the input closed after a word
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##8 !in_ready)
    else $error("input reopened during the multiply");

  // the block comes out of reset ready for a word
  a_ready_after_rst: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

  // register reads show only the five length bits
  a_prdata_narrow: assert property (@(posedge clk)
    pready && prdata[APB_DW-1:LEN_W] == '0)
    else $error("register read out of range");

endmodule

bind rms_group_combiner_unit rgc_props u_rgc_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (rms_ch.valid),
  .in_ready  (rms_ch.ready),
  .out_valid (level_ch.valid),
  .out_ready (level_ch.ready),
  .pready    (pready),
  .prdata    (prdata)
);

/* test/rgc_checker.sv */
`timescale 1ns / 100ps

module rgc_checker
  import rgc_pkg::*;
#(
  parameter int                GROUPS_PER_FRAME = DEF_GROUPS_PER_FRAME,
  parameter logic [APB_AW-1:0] LEN_ADDR         = '0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  rgc_in_if                 rms_mon,
  rgc_out_if                level_mon,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [RMS_W-1:0] fast_level;
    logic             frame_end;
  } level_t;

  level_t            level_q[$];
  logic [LEN_W-1:0]  len_reg;
  logic [SUM_W-1:0]  sq_sum;
  logic [LEN_W-1:0]  word_cnt;
  logic [GCNT_W-1:0] frame_pos;
  int                errs;

  // root found one bit at a time from the top, kept to the output width
  function automatic logic [RMS_W-1:0] floor_root(input logic [SUM_W-1:0] v);
    logic [ROOT_W-1:0]   root;
    logic [ROOT_W-1:0]   trial;
    logic [2*ROOT_W-1:0] prod;
    int                  b;
    root = '0;
    for (b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (ROOT_W'(1) << b);
      prod  = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);
      if (prod <= (2*ROOT_W)'(v)) begin
        root = trial;
      end
    end
    return root[RMS_W-1:0];
  endfunction

  task automatic take_rms(input logic [RMS_W-1:0] x);
    logic [LEN_W-1:0] n;
    level_t           lv;
    n = len_reg;
    if (n == '0) begin
      n = LEN_W'(1);
    end else if (n > MAX_GROUP_LEN) begin
      n = MAX_GROUP_LEN;
    end
    sq_sum   = sq_sum + SUM_W'(x) * SUM_W'(x);
    word_cnt = word_cnt + 1'b1;
    if (word_cnt >= n) begin
      lv.fast_level = floor_root(sq_sum / SUM_W'(n));
      lv.frame_end  = (int'(frame_pos) + 1 >= GROUPS_PER_FRAME);
      frame_pos     = lv.frame_end ? '0 : frame_pos + 1'b1;
      sq_sum        = '0;
      word_cnt      = '0;
      level_q.push_back(lv);
    end
  endtask

  always @(posedge clk) begin : watch
    level_t want;
    if (rst) begin
      level_q.delete();
      len_reg   = GROUP_LEN_RESET;
      sq_sum    = '0;
      word_cnt  = '0;
      frame_pos = '0;
      errs      = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == LEN_ADDR) begin
        len_reg = pwdata[LEN_W-1:0];
      end
      if (level_mon.valid && level_mon.ready) begin
        if (level_q.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("%0t: level %h frame_end %b with nothing expected", $realtime,
                     level_mon.fast_level, level_mon.frame_end);
          end
        end else begin
          want = level_q.pop_front();
          if (want.fast_level !== level_mon.fast_level
              || want.frame_end !== level_mon.frame_end) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: level %h frame_end %b, expected level %h frame_end %b",
                       $realtime, level_mon.fast_level, level_mon.frame_end,
                       want.fast_level, want.frame_end);
            end
          end
        end
      end
      if (rms_mon.valid && rms_mon.ready) begin
        take_rms(rms_mon.rms_value);
      end
    end
    fail_count <= errs;
    pending    <= level_q.size();
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import rgc_pkg::*;

  localparam logic [APB_AW-1:0] GROUP_LEN_ADDR = '0;
  localparam int FRAME_GROUPS = DEF_GROUPS_PER_FRAME;
  localparam int RANDOM_WORDS = 1850;
  // a closing word runs the multiply, divide and root steps, leave some margin
  localparam int QUIET_CYCLES = 100;
  // bound for the slowest run
  localparam int CYCLE_LIMIT  = 1000000;

  // directed words for the reset group length: extremes and bit patterns
  localparam logic [9:0][RMS_W-1:0] EDGE_WORDS = {
    16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h0001,
    16'h8000, 16'hFFFF, 16'h7FFF, 16'hFFFE, 16'h00FF
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  int                cycles = 0;
  bit                source_gaps;
  bit                sink_stalls;

  rgc_in_if  rms_in ();
  rgc_out_if level_out ();

  rms_group_combiner_unit #(
    .GROUPS_PER_FRAME(FRAME_GROUPS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rms_ch  (rms_in),
    .level_ch(level_out)
  );

  // watches both channels and the register port, predicts every level
  rgc_checker #(
    .GROUPS_PER_FRAME(FRAME_GROUPS),
    .LEN_ADDR        (GROUP_LEN_ADDR)
  ) level_check (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .rms_mon   (rms_in),
    .level_mon (level_out),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // 2 ns period, first rising edge at 1 ns
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // level sink: random stall before each word, ready held until a word is taken
  initial begin : level_sink
    int stall;
    level_out.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = sink_stalls ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        level_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      level_out.ready <= 1'b1;
      @(posedge clk);
      while (!level_out.valid) @(posedge clk);
    end
  end

  // one register write: setup cycle, then access cycle until pready
  task automatic write_len(input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GROUP_LEN_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // valid stays high across back-to-back words, only dropped for a gap
  task automatic send_word(input logic [RMS_W-1:0] v);
    int gap;
    gap = source_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      rms_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rms_in.valid     <= 1'b1;
    rms_in.rms_value <= v;
    @(posedge clk);
    while (!rms_in.ready) @(posedge clk);
  endtask

  // hold off input until every predicted level is out and the block is quiet
  task automatic settle();
    rms_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // group length with junk in the unused upper bits
  function automatic logic [APB_DW-1:0] pick_len();
    logic [APB_DW-1:0] d;
    d = $urandom;
    case ($urandom_range(0, 7))
      0: d[LEN_W-1:0] = '0;
      1: d[LEN_W-1:0] = LEN_W'(1);
      2: d[LEN_W-1:0] = MAX_GROUP_LEN;
      3: d[LEN_W-1:0] = LEN_W'($urandom_range(17, 31));
      default: d[LEN_W-1:0] = LEN_W'($urandom_range(1, 16));
    endcase
    return d;
  endfunction

  // rms level mix: extremes, small, one-hot, near full scale, uniform
  function automatic logic [RMS_W-1:0] pick_rms();
    logic [RMS_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = RMS_W'($urandom_range(0, 255));
      3: v = RMS_W'(1) << $urandom_range(0, RMS_W - 1);
      4, 5: v = RMS_W'($urandom_range(60000, 65535));
      default: v = RMS_W'($urandom);
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int n_words;
    int sent;
    int k;
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    rms_in.valid     <= 1'b0;
    rms_in.rms_value <= '0;
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset group length of ten: exactly one level
    for (k = 9; k >= 0; k--) begin
      send_word(EDGE_WORDS[k]);
    end
    // four full-scale words leave a group open
    for (k = 0; k < 4; k++) begin
      send_word('1);
    end
    settle();
    // zero length acts as one: the open group closes on the next word, the
    // sum of five full-scale squares over one has a root wider than the output
    write_len('0);
    send_word('1);
    settle();
    write_len(APB_DW'(1));
    send_word('0);
    send_word(16'h8000);
    send_word(16'h0001);
    settle();
    // all ones: length clamps to sixteen, group left open for the next phase
    write_len('1);
    for (k = 0; k < 7; k++) begin
      send_word('1);
    end

    // random phases, new group length between phases, often mid-group
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      settle();
      write_len(pick_len());
      source_gaps = $urandom_range(0, 3) != 0;
      sink_stalls = $urandom_range(0, 3) != 0;
      n_words = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : $urandom_range(10, 150);
      for (k = 0; k < n_words; k++) begin
        send_word(pick_rms());
      end
      sent += n_words;
    end
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
